### rtl/core/unix_seconds_to_calendar_core_macros.svh
// assertion macros used by the calendar core top level
`ifndef UNIX_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
`define UNIX_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
// consequent must hold in the same cycle as the antecedent
`define UCAL_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ucal check failed");
// consequent must hold in the cycle after the antecedent
`define UCAL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ucal check failed");
`endif

### rtl/core/ucal_pkg.sv
// types, constants and helpers of the seconds to calendar converter
package ucal_pkg;

    localparam int NUM_STAGES = 11;

    localparam int TZ_W   = 12;
    localparam int UNIX_W = 39;
    localparam int U_W    = 40;
    localparam int DAYS_W = 23;
    localparam int SECS_W = 17;
    localparam int YEAR_W = 16;
    localparam int YDAY_W = 9;

    localparam longint SECS_PER_DAY      = 60 * 60 * 24;
    localparam longint DAYS_1970_TO_2001 = 365 * 31 + 8;
    localparam longint DAYS_400Y         = 365 * 400 + 97;
    localparam longint DAYS_100Y         = 365 * 100 + 24;
    localparam longint DAYS_4Y           = 365 * 4 + 1;
    localparam longint DAYS_1Y           = 365;
    localparam longint BASE_YEAR         = 2001;
    // whole 400-year cycles added so the biased count is never negative
    localparam longint CYCLE_BIAS        = 22;

    localparam longint TIME_OFFSET =
        (CYCLE_BIAS * DAYS_400Y - DAYS_1970_TO_2001) * SECS_PER_DAY;
    localparam logic [U_W-1:0] TIME_OFFSET_U = U_W'(TIME_OFFSET);

    // 86400 = 128 * 675, the power of two is split off first
    localparam int            DAY_SHIFT       = 7;
    localparam longint        DAY_ODD_L       = SECS_PER_DAY >> DAY_SHIFT;
    localparam logic [10:0]   DAY_ODD         = 11'(DAY_ODD_L);
    localparam int            DAY_RECIP_SHIFT = 33;
    // truncated reciprocal, quotient is low by at most one
    localparam logic [23:0]   DAY_RECIP =
        24'((longint'(1) << DAY_RECIP_SHIFT) / DAY_ODD_L);

    // rounded-up reciprocals, exact over the operand range
    localparam int          CYC_RECIP_SHIFT = 41;
    localparam logic [23:0] CYC_RECIP =
        24'(((longint'(1) << CYC_RECIP_SHIFT) + DAYS_400Y - 1) / DAYS_400Y);
    localparam int          QUAD_RECIP_SHIFT = 27;
    localparam logic [16:0] QUAD_RECIP =
        17'(((longint'(1) << QUAD_RECIP_SHIFT) + DAYS_4Y - 1) / DAYS_4Y);
    localparam int          HOUR_RECIP_SHIFT = 29;
    localparam logic [17:0] HOUR_RECIP =
        18'(((longint'(1) << HOUR_RECIP_SHIFT) + 3600 - 1) / 3600);
    localparam int          MIN_RECIP_SHIFT = 18;
    localparam logic [12:0] MIN_RECIP =
        13'(((longint'(1) << MIN_RECIP_SHIFT) + 60 - 1) / 60);

    localparam logic [17:0] DAYS_400Y_W  = 18'(DAYS_400Y);
    localparam logic [17:0] DAYS_100Y_W  = 18'(DAYS_100Y);
    localparam logic [17:0] DAYS_200Y_W  = 18'(2 * DAYS_100Y);
    localparam logic [17:0] DAYS_300Y_W  = 18'(3 * DAYS_100Y);
    localparam logic [10:0] DAYS_4Y_W    = 11'(DAYS_4Y);
    localparam logic [10:0] DAYS_1Y_W    = 11'(DAYS_1Y);
    localparam logic [10:0] DAYS_2Y_W    = 11'(2 * DAYS_1Y);
    localparam logic [10:0] DAYS_3Y_W    = 11'(3 * DAYS_1Y);
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    localparam logic [YEAR_W-1:0] YEAR_BASE = YEAR_W'(BASE_YEAR - CYCLE_BIAS * 400);
    localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE   = 16'd400;
    localparam logic [YEAR_W-1:0] YEARS_PER_CENTURY = 16'd100;
    localparam logic signed [YEAR_W-1:0] MAX_YEAR = 16'sd9999;

    // block indexes that decide the leap rule
    localparam logic [1:0] LAST_CENTURY = 2'd3;
    localparam logic [4:0] LAST_QUAD    = 5'd24;
    localparam logic [1:0] LAST_YEAR    = 2'd3;

    localparam logic [YDAY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SECS_W-1:0] secs;
    } day_split_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [YDAY_W-1:0] yday;
        logic              leap;
    } ydate_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } mday_t;

    // day of year to month and day of month, one compare per month
    function automatic mday_t month_day(input logic [YDAY_W-1:0] yday, input logic leap);
        mday_t             res;
        logic [YDAY_W-1:0] start;
        logic [YDAY_W-1:0] sel;
        res.month = 4'd1;
        sel = '0;
        for (int i = 0; i < 12; i++) begin
            start = MONTH_START[i] + ((leap && (i >= 2)) ? 9'd1 : 9'd0);
            if (yday >= start) begin
                res.month = 4'(i + 1);
                sel = start;
            end
        end
        res.day = 5'(yday - sel + 9'd1);
        return res;
    endfunction

endpackage

### rtl/core/unix_seconds_to_calendar_core.sv
// top level of the unix seconds to local calendar date and time converter
// usage:
//  - input channel s_*: one word per accepted s_valid/s_ready, a signed 39-bit
//    count of seconds since 1970-01-01 utc
//  - result channel m_*: one word per input word, in order: local year, month,
//    day, hour, minute, second, and out_of_range when the year leaves 0..9999
//    (then every other field reads zero)
//  - apb port: register 0 at byte address 0 is tz_offset_minutes, a signed
//    12-bit offset east of utc; write it only while the block is idle
//  - throughput: one word per cycle while m_ready does not stall, set by the
//    11-stage pipeline in which every stage holds one word
//  - each stage moves when the stage after it is empty or moving, so a stall
//    on m_ready fills the empty stages first and s_ready drops only when every
//    stage holds a word; bubbles are squeezed out
//  - reset (aresetn low, synchronous) empties the pipeline and clears the
//    offset to zero; the data registers are not reset
`include "unix_seconds_to_calendar_core_macros.svh"

module unix_seconds_to_calendar_core
    import ucal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [UNIX_W-1:0] s_unix_seconds,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [13:0]              m_year,
    output logic [3:0]               m_month,
    output logic [4:0]               m_day,
    output logic [4:0]               m_hour,
    output logic [5:0]               m_minute,
    output logic [5:0]               m_second,
    output logic                     m_out_of_range
);

    localparam int OUT_STAGE = NUM_STAGES - 1;
    // register index taken from the word address bit
    localparam logic REG_TZ_OFFSET = 1'b0;

    logic signed [TZ_W-1:0] tz_reg;
    logic                   tz_write;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_space;
    logic [NUM_STAGES-1:0] stage_feed;

    day_split_t split;
    ydate_t     ydate;
    tod_t       tod;
    mday_t      mday;
    logic       oor_next;

    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic        oor_reg;

    // result word checks for the assertions
    logic res_zero;
    logic res_legal;

    // configuration register
    assign pready   = 1'b1;
    assign tz_write = psel && penable && pwrite && (paddr[2] == REG_TZ_OFFSET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tz_reg <= '0;
        end else if (tz_write) begin
            tz_reg <= pwdata[TZ_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TZ_OFFSET) ? {{(32 - TZ_W){tz_reg[TZ_W-1]}}, tz_reg}
                                               : '0;

    // pipeline flow: a stage may load when empty or when its word moves on
    always_comb begin
        stage_space[OUT_STAGE] = !valid_reg[OUT_STAGE] || m_ready;
        for (int k = OUT_STAGE - 1; k >= 0; k--) begin
            stage_space[k] = !valid_reg[k] || stage_space[k+1];
        end
    end

    assign stage_feed = {valid_reg[NUM_STAGES-2:0], s_valid};
    assign valid_next = (stage_space & stage_feed) | (~stage_space & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_space[0];
    assign m_valid = valid_reg[OUT_STAGE];

    // stages 0 to 3: local time split into days and seconds of day
    ucal_day_split u_split (
        .aclk              (aclk),
        .stage_en          (stage_space[3:0]),
        .tz_offset_minutes (tz_reg),
        .unix_seconds      (s_unix_seconds),
        .split             (split)
    );

    // stages 4 to 9: date and time of day side by side
    ucal_year u_year (
        .aclk     (aclk),
        .stage_en (stage_space[9:4]),
        .days     (split.days),
        .ydate    (ydate)
    );

    ucal_tod u_tod (
        .aclk     (aclk),
        .stage_en (stage_space[9:4]),
        .secs     (split.secs),
        .tod      (tod)
    );

    // stage 10: month walk, range check and the result register
    assign mday     = month_day(ydate.yday, ydate.leap);
    assign oor_next = ($signed(ydate.year) < 0) || ($signed(ydate.year) > MAX_YEAR);

    always_ff @(posedge aclk) begin
        if (stage_space[OUT_STAGE]) begin
            if (oor_next) begin
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
            end else begin
                year_reg   <= ydate.year[13:0];
                month_reg  <= mday.month;
                day_reg    <= mday.day;
                hour_reg   <= tod.hour;
                minute_reg <= tod.minute;
                second_reg <= tod.second;
            end
            oor_reg <= oor_next;
        end
    end

    assign m_year         = year_reg;
    assign m_month        = month_reg;
    assign m_day          = day_reg;
    assign m_hour         = hour_reg;
    assign m_minute       = minute_reg;
    assign m_second       = second_reg;
    assign m_out_of_range = oor_reg;

    assign res_zero  = (m_year == '0) && (m_month == '0) && (m_day == '0)
                       && (m_hour == '0) && (m_minute == '0) && (m_second == '0);
    assign res_legal = (m_month >= 4'd1) && (m_month <= 4'd12) && (m_day >= 5'd1)
                       && (m_day <= 5'd31) && (m_hour <= 5'd23) && (m_minute <= 6'd59)
                       && (m_second <= 6'd59);

    // an out-of-range word carries nothing but the flag
    `UCAL_ASSERT_SAME(a_oor_zero, m_valid && m_out_of_range, res_zero)

    // a valid date and time of day in range
    `UCAL_ASSERT_SAME(a_fields_legal, m_valid && !m_out_of_range, res_legal)

    // an empty result register means every stage can load
    `UCAL_ASSERT_SAME(a_ready_when_drained, !m_valid, s_ready)

    // offset write lands in the register
    `UCAL_ASSERT_NEXT(a_tz_write, tz_write, tz_reg == $past(pwdata[TZ_W-1:0]))

endmodule

### rtl/core/ucal_day_split.sv
// front stages: offset add, rebase and split into days and seconds of day
module ucal_day_split
    import ucal_pkg::*;
(
    input  logic                     aclk,
    input  logic [3:0]               stage_en,
    input  logic signed [TZ_W-1:0]   tz_offset_minutes,
    input  logic signed [UNIX_W-1:0] unix_seconds,
    output day_split_t               split
);

    logic [UNIX_W-1:0] unix_reg;
    logic [U_W-1:0]    unix_ext;
    logic [U_W-1:0]    tz_ext;
    logic [U_W-1:0]    tz_secs;
    logic [U_W-1:0]    biased_next;
    logic [U_W-1:0]    biased_reg;
    logic [56:0]       day_prod;
    logic [DAYS_W-1:0] q0_next;
    logic [DAYS_W-1:0] q0_reg;
    logic [17:0]       low_reg;
    logic [10:0]       q0_scaled;
    logic [10:0]       r0;
    logic              fix;
    logic [9:0]        rem;
    day_split_t        split_next;
    day_split_t        split_reg;

    // stage 0: input word
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            unix_reg <= unix_seconds;
        end
    end

    // stage 1: local time, rebased and biased to a positive count
    assign unix_ext = {{(U_W - UNIX_W){unix_reg[UNIX_W-1]}}, unix_reg};
    assign tz_ext   = {{(U_W - TZ_W){tz_offset_minutes[TZ_W-1]}}, tz_offset_minutes};
    assign tz_secs  = (tz_ext << 6) - (tz_ext << 2);
    assign biased_next = unix_ext + tz_secs + TIME_OFFSET_U;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            biased_reg <= biased_next;
        end
    end

    // stage 2: estimate of (count / 128) / 675
    assign day_prod = {24'd0, biased_reg[U_W-1:DAY_SHIFT]} * {33'd0, DAY_RECIP};
    assign q0_next  = day_prod[DAY_RECIP_SHIFT+DAYS_W-1:DAY_RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            q0_reg  <= q0_next;
            low_reg <= biased_reg[17:0];
        end
    end

    // stage 3: remainder below 2*675, so one correction step
    assign q0_scaled = q0_reg[10:0] * DAY_ODD;
    assign r0        = low_reg[17:DAY_SHIFT] - q0_scaled;
    assign fix       = (r0 >= DAY_ODD);
    assign rem       = fix ? 10'(r0 - DAY_ODD) : r0[9:0];

    always_comb begin
        split_next.days = q0_reg + {{(DAYS_W - 1){1'b0}}, fix};
        split_next.secs = {rem, low_reg[DAY_SHIFT-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            split_reg <= split_next;
        end
    end

    assign split = split_reg;

endmodule

### rtl/core/ucal_year.sv
// year and day of year by peeling 400, 100, 4 and 1 year blocks
module ucal_year
    import ucal_pkg::*;
(
    input  logic              aclk,
    input  logic [5:0]        stage_en,
    input  logic [DAYS_W-1:0] days,
    output ydate_t            ydate
);

    logic [46:0]       cyc_prod;
    logic [5:0]        q400_reg;
    logic [DAYS_W-1:0] days_reg;

    logic [17:0]       cyc_days;
    logic [17:0]       d400_next;
    logic [17:0]       d400_reg;
    logic [YEAR_W-1:0] y400_next;
    logic [YEAR_W-1:0] y400_reg;

    logic              c1, c2, c3;
    logic [1:0]        q100_next;
    logic [17:0]       cent_days;
    logic [15:0]       d100_next;
    logic [15:0]       d100_s6_reg;
    logic [1:0]        q100_s6_reg;
    logic [YEAR_W-1:0] y100_next;
    logic [YEAR_W-1:0] y100_s6_reg;

    logic [32:0]       quad_prod;
    logic [4:0]        q4_next;
    logic [4:0]        q4_s7_reg;
    logic [15:0]       d100_s7_reg;
    logic [1:0]        q100_s7_reg;
    logic [YEAR_W-1:0] y100_s7_reg;

    logic [10:0]       quad_days;
    logic [10:0]       d4_next;
    logic [10:0]       d4_reg;
    logic [4:0]        q4_s8_reg;
    logic [1:0]        q100_s8_reg;
    logic [YEAR_W-1:0] y4_next;
    logic [YEAR_W-1:0] y4_reg;

    logic              a1, a2, a3;
    logic [1:0]        q1;
    logic [8:0]        year_days;
    ydate_t            ydate_next;
    ydate_t            ydate_reg;

    // stage 4: 400-year cycle count
    assign cyc_prod = {24'd0, days} * {23'd0, CYC_RECIP};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            q400_reg <= cyc_prod[CYC_RECIP_SHIFT+5:CYC_RECIP_SHIFT];
            days_reg <= days;
        end
    end

    // stage 5: day inside the cycle, fits in 18 bits
    assign cyc_days  = {12'd0, q400_reg} * DAYS_400Y_W;
    assign d400_next = days_reg[17:0] - cyc_days;
    assign y400_next = YEAR_BASE + ({10'd0, q400_reg} * YEARS_PER_CYCLE);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            d400_reg <= d400_next;
            y400_reg <= y400_next;
        end
    end

    // stage 6: century, capped at three for the cycle's last day
    assign c1 = (d400_reg >= DAYS_100Y_W);
    assign c2 = (d400_reg >= DAYS_200Y_W);
    assign c3 = (d400_reg >= DAYS_300Y_W);
    assign q100_next = 2'(c1) + 2'(c2) + 2'(c3);
    assign cent_days = c3 ? DAYS_300Y_W : (c2 ? DAYS_200Y_W : (c1 ? DAYS_100Y_W : '0));
    assign d100_next = 16'(d400_reg - cent_days);
    assign y100_next = y400_reg + ({14'd0, q100_next} * YEARS_PER_CENTURY);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            d100_s6_reg <= d100_next;
            q100_s6_reg <= q100_next;
            y100_s6_reg <= y100_next;
        end
    end

    // stage 7: 4-year block count
    assign quad_prod = {17'd0, d100_s6_reg} * {16'd0, QUAD_RECIP};
    assign q4_next   = quad_prod[QUAD_RECIP_SHIFT+4:QUAD_RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            q4_s7_reg   <= q4_next;
            d100_s7_reg <= d100_s6_reg;
            q100_s7_reg <= q100_s6_reg;
            y100_s7_reg <= y100_s6_reg;
        end
    end

    // stage 8: day inside the 4-year block
    assign quad_days = {6'd0, q4_s7_reg} * DAYS_4Y_W;
    assign d4_next   = d100_s7_reg[10:0] - quad_days;
    assign y4_next   = y100_s7_reg + {9'd0, q4_s7_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            d4_reg      <= d4_next;
            q4_s8_reg   <= q4_s7_reg;
            q100_s8_reg <= q100_s7_reg;
            y4_reg      <= y4_next;
        end
    end

    // stage 9: single years, capped at three for the last day of the block
    assign a1 = (d4_reg >= DAYS_1Y_W);
    assign a2 = (d4_reg >= DAYS_2Y_W);
    assign a3 = (d4_reg >= DAYS_3Y_W);
    assign q1 = 2'(a1) + 2'(a2) + 2'(a3);
    assign year_days = 9'({9'd0, q1} * DAYS_1Y_W);

    always_comb begin
        ydate_next.year = y4_reg + {14'd0, q1};
        ydate_next.yday = d4_reg[8:0] - year_days;
        ydate_next.leap = (q1 == LAST_YEAR)
                          && ((q4_s8_reg != LAST_QUAD) || (q100_s8_reg == LAST_CENTURY));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            ydate_reg <= ydate_next;
        end
    end

    assign ydate = ydate_reg;

endmodule

### rtl/core/ucal_tod.sv
// hour, minute and second from the seconds of the day
module ucal_tod
    import ucal_pkg::*;
(
    input  logic              aclk,
    input  logic [5:0]        stage_en,
    input  logic [SECS_W-1:0] secs,
    output tod_t              tod
);

    logic [34:0]       hour_prod;
    logic [4:0]        hour_s4_reg;
    logic [SECS_W-1:0] secs_reg;

    logic [11:0]       hour_secs;
    logic [11:0]       rem_h_next;
    logic [11:0]       rem_h_s5_reg;
    logic [4:0]        hour_s5_reg;

    logic [24:0]       min_prod;
    logic [5:0]        min_s6_reg;
    logic [11:0]       rem_h_s6_reg;
    logic [4:0]        hour_s6_reg;

    logic [5:0]        min_secs;
    tod_t              tod_next;
    tod_t              tod_s7_reg;
    tod_t              tod_s8_reg;
    tod_t              tod_s9_reg;

    // stage 4: hour
    assign hour_prod = {18'd0, secs} * {17'd0, HOUR_RECIP};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            hour_s4_reg <= hour_prod[HOUR_RECIP_SHIFT+4:HOUR_RECIP_SHIFT];
            secs_reg    <= secs;
        end
    end

    // stage 5: seconds inside the hour
    assign hour_secs  = {7'd0, hour_s4_reg} * SECS_PER_HOUR;
    assign rem_h_next = secs_reg[11:0] - hour_secs;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            rem_h_s5_reg <= rem_h_next;
            hour_s5_reg  <= hour_s4_reg;
        end
    end

    // stage 6: minute
    assign min_prod = {13'd0, rem_h_s5_reg} * {12'd0, MIN_RECIP};

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            min_s6_reg   <= min_prod[MIN_RECIP_SHIFT+5:MIN_RECIP_SHIFT];
            rem_h_s6_reg <= rem_h_s5_reg;
            hour_s6_reg  <= hour_s5_reg;
        end
    end

    // stage 7: second, then delay to line up with the date path
    assign min_secs = min_s6_reg * SECS_PER_MIN;

    always_comb begin
        tod_next.hour   = hour_s6_reg;
        tod_next.minute = min_s6_reg;
        tod_next.second = rem_h_s6_reg[5:0] - min_secs;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            tod_s7_reg <= tod_next;
        end
        if (stage_en[4]) begin
            tod_s8_reg <= tod_s7_reg;
        end
        if (stage_en[5]) begin
            tod_s9_reg <= tod_s8_reg;
        end
    end

    assign tod = tod_s9_reg;

endmodule

### sim/tb_unix_seconds_to_calendar_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the unix seconds to local calendar date and time converter
module tb_unix_seconds_to_calendar_core
    import ucal_pkg::*;
();

    // calendar constants used by the date predictor
    localparam longint DAY_SECS           = 60 * 60 * 24;
    localparam longint EPOCH_TO_2001_DAYS = 365 * 31 + 8;
    localparam longint CYCLE_DAYS         = 365 * 400 + 97;
    localparam longint CENTURY_DAYS       = 365 * 100 + 24;
    localparam longint QUAD_DAYS          = 365 * 4 + 1;
    localparam longint YEAR_DAYS          = 365;
    localparam longint FIRST_YEAR         = 2001;

    // 0000-01-01T00:00:00 and 9999-12-31T23:59:59 utc
    localparam longint          MIN_SECONDS = -62167219200;
    localparam longint          MAX_SECONDS = 253402300799;
    localparam longint unsigned SPAN        = MAX_SECONDS - MIN_SECONDS + 1;

    // register byte addresses: only the offset exists, the other one is decoded as nothing
    localparam logic [2:0] TZ_ADDR     = 3'd0;
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    localparam int DRAIN_CYCLES    = 14;    // pipeline latency plus margin
    localparam int QUIET_LIMIT     = 1000;  // cycles with no word moving before giving up
    localparam int WORDS_PER_PHASE = 255;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        out_of_range;
    } calendar_fields_t;

    logic                     aclk;
    logic                     aresetn        = 1'b0;
    logic                     psel           = 1'b0;
    logic                     penable        = 1'b0;
    logic                     pwrite         = 1'b0;
    logic [2:0]               paddr          = '0;
    logic [31:0]              pwdata         = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [UNIX_W-1:0] s_unix_seconds = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [13:0]              m_year;
    logic [3:0]               m_month;
    logic [4:0]               m_day;
    logic [4:0]               m_hour;
    logic [5:0]               m_minute;
    logic [5:0]               m_second;
    logic                     m_out_of_range;

    // offset as the block should hold it, and the dates still owed by the block
    logic signed [11:0] tz_model = '0;
    calendar_fields_t   pending_dates[$];

    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;

    int words_sent   = 0;
    int results_seen = 0;
    int range_misses = 0;
    int tz_writes    = 0;
    int error_count  = 0;
    int quiet_cycles = 0;

    unix_seconds_to_calendar_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_unix_seconds (s_unix_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day          (m_day),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .m_out_of_range (m_out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // quotient rounded toward minus infinity, remainder left in [0, d)
    function automatic longint floor_div(input longint n, input longint d, output longint rem);
        longint q;
        q   = n / d;
        rem = n % d;
        if (rem < 0) begin
            q--;
            rem += d;
        end
        return q;
    endfunction

    // seconds since the epoch of a proleptic gregorian date, built by an independent
    // days-from-civil count so the directed words land exactly on their dates
    function automatic longint seconds_at(input longint y, input longint mo, input longint d,
                                          input longint hh, input longint mi, input longint ss);
        longint yy, era, yoe, doy, doe;
        yy  = (mo <= 2) ? y - 1 : y;
        era = (yy >= 0 ? yy : yy - 399) / 400;
        yoe = yy - era * 400;
        doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return (era * CYCLE_DAYS + doe - 719468) * DAY_SECS + hh * 3600 + mi * 60 + ss;
    endfunction

    // local date and time of one word under a given offset
    function automatic calendar_fields_t local_calendar_of(input logic [UNIX_W-1:0] raw,
                                                            input logic signed [11:0] tz);
        calendar_fields_t f;
        longint           t, tod, days, rest, year, q, dim;
        logic             leap;
        int               mon;
        // rebase to 2001-01-01, the first day of a 400-year cycle
        t    = longint'($signed(raw)) + longint'(tz) * 60 - DAY_SECS * EPOCH_TO_2001_DAYS;
        days = floor_div(t, DAY_SECS, tod);
        year = FIRST_YEAR + floor_div(days, CYCLE_DAYS, rest) * 400;
        days = rest;
        // the last day of a 400-year cycle would give a fourth century without the cap
        q = days / CENTURY_DAYS;
        if (q > 3)
            q = 3;
        days -= q * CENTURY_DAYS;
        year += q * 100;
        year += (days / QUAD_DAYS) * 4;
        days  = days % QUAD_DAYS;
        // same for dec 31 of the leap year closing a 4-year block
        q = days / YEAR_DAYS;
        if (q > 3)
            q = 3;
        days -= q * YEAR_DAYS;
        year += q;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        mon  = 1;
        for (int i = 0; i < 11; i++) begin
            case (i)
                1:          dim = leap ? 29 : 28;
                3, 5, 8, 10: dim = 30;
                default:    dim = 31;
            endcase
            if (days < dim)
                break;
            days -= dim;
            mon++;
        end
        f = '0;
        if (year < 0 || year > 9999) begin
            f.out_of_range = 1'b1;
        end else begin
            f.year   = 14'(year);
            f.month  = 4'(mon);
            f.day    = 5'(days + 1);
            f.hour   = 5'(tod / 3600);
            f.minute = 6'((tod % 3600) / 60);
            f.second = 6'(tod % 60);
        end
        return f;
    endfunction

    // random word: mostly dates in the stated range, then year and leap edges
    // in local time, words around the range limits, and raw 39-bit noise
    function automatic logic [UNIX_W-1:0] pick_seconds(input logic signed [11:0] tz);
        longint unsigned raw;
        longint          shift, y, value;
        int              kind;
        raw   = {$urandom, $urandom};
        shift = longint'(tz) * 60;
        kind  = $urandom_range(0, 99);
        if (kind < 55) begin
            value = MIN_SECONDS + longint'(raw % SPAN);
        end else if (kind < 75) begin
            y = $urandom_range(0, 9999);
            case ($urandom_range(0, 3))
                0:       value = seconds_at(y, 1, 1, 0, 0, 0);
                1:       value = seconds_at(y, 12, 31, 23, 59, 59);
                2:       value = seconds_at(y, 2, 29, 0, 0, 0);
                default: value = seconds_at(y, 2, 28, 23, 59, 59);
            endcase
            value = value - shift + longint'($urandom_range(0, 4)) - 2;
        end else if (kind < 88) begin
            value = (raw[0] ? MAX_SECONDS : MIN_SECONDS) - shift
                    + longint'($urandom_range(0, 518400)) - 259200;
        end else begin
            value = longint'(raw);
        end
        return UNIX_W'(value);
    endfunction

    // all driving tasks start and end just after a falling edge

    // apb write: setup cycle, then access cycle, register taken at the rising edge
    task automatic write_register(input logic [2:0] addr, input logic signed [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == TZ_ADDR)
            tz_model = value;
        tz_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one word on the input channel, after a random gap when gaps are enabled
    task automatic send_seconds(input logic [UNIX_W-1:0] value);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_unix_seconds <= value;
        do @(posedge aclk); while (!s_ready);
        pending_dates.push_back(local_calendar_of(value, tz_model));
        words_sent++;
        @(negedge aclk);
    endtask

    // stop sending until every owed date is back, then let the pipeline settle
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // both ends of the 39-bit field and of the stated range, and the epoch itself
    task automatic test_field_extremes();
        drain_pipeline();
        write_register(TZ_ADDR, 12'sd0);
        send_seconds({1'b1, {(UNIX_W-1){1'b0}}});
        send_seconds({1'b0, {(UNIX_W-1){1'b1}}});
        send_seconds(UNIX_W'(MIN_SECONDS));
        send_seconds(UNIX_W'(MIN_SECONDS - 1));
        send_seconds(UNIX_W'(MAX_SECONDS));
        send_seconds(UNIX_W'(MAX_SECONDS + 1));
        send_seconds(UNIX_W'(0));
        send_seconds(UNIX_W'(-1));
    endtask

    // last days of 4-year, 100-year and 400-year blocks, and leap day edges
    task automatic test_block_boundaries();
        send_seconds(UNIX_W'(seconds_at(2004, 12, 31, 12, 0, 0)));
        send_seconds(UNIX_W'(seconds_at(2400, 12, 31, 23, 59, 59)));
        send_seconds(UNIX_W'(seconds_at(2000, 12, 31, 0, 0, 0)));
        send_seconds(UNIX_W'(seconds_at(2000, 2, 29, 6, 30, 15)));
        send_seconds(UNIX_W'(seconds_at(1900, 2, 28, 23, 59, 59)));
        send_seconds(UNIX_W'(seconds_at(1900, 3, 1, 0, 0, 0)));
        send_seconds(UNIX_W'(seconds_at(2100, 12, 31, 23, 59, 59)));
        send_seconds(UNIX_W'(seconds_at(1600, 12, 31, 0, 0, 1)));
    endtask

    // offsets beyond a day push the range ends across the year limits;
    // a write to an unused address must leave the offset alone
    task automatic test_offset_extremes();
        drain_pipeline();
        write_register(TZ_ADDR, 12'sh7FF);
        send_seconds(UNIX_W'(MAX_SECONDS));
        send_seconds(UNIX_W'(MIN_SECONDS));
        drain_pipeline();
        write_register(TZ_ADDR, 12'sh800);
        send_seconds(UNIX_W'(MAX_SECONDS));
        send_seconds(UNIX_W'(MIN_SECONDS));
        drain_pipeline();
        write_register(UNUSED_ADDR, 12'sd100);
        send_seconds(UNIX_W'(0));
        drain_pipeline();
        write_register(TZ_ADDR, 12'sd1440);
        send_seconds(UNIX_W'(0));
        drain_pipeline();
        write_register(TZ_ADDR, -12'sd1440);
        send_seconds(UNIX_W'(0));
    endtask

    // random words in phases, one offset per phase; every phase boundary drains
    // the block completely, and the idle pattern is redrawn every 50 words
    task automatic test_random_dates();
        logic signed [11:0] phase_tz;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       phase_tz = 12'sd0;
                1:       phase_tz = 12'sd330;
                2:       phase_tz = -12'sd1440;
                3:       phase_tz = 12'sd1440;
                default: phase_tz = 12'($urandom_range(0, 4095));
            endcase
            drain_pipeline();
            write_register(TZ_ADDR, phase_tz);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    send_gaps_on   = ($urandom_range(0, 3) != 0);
                    recv_stalls_on = ($urandom_range(0, 3) != 0);
                end
                send_seconds(pick_seconds(phase_tz));
            end
        end
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
    endtask

    // result side: random stall before each word, none while stalls are off
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = recv_stalls_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // every accepted result word against the oldest owed date
    always @(posedge aclk) begin : check_results
        calendar_fields_t want;
        calendar_fields_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_year, m_month, m_day, m_hour, m_minute, m_second, m_out_of_range};
            results_seen++;
            if (pending_dates.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("result word %0d arrived with nothing owed", results_seen);
                error_count++;
            end else begin
                want = pending_dates.pop_front();
                if (want.out_of_range)
                    range_misses++;
                if (got.year !== want.year || got.month !== want.month
                        || got.day !== want.day || got.hour !== want.hour
                        || got.minute !== want.minute || got.second !== want.second
                        || got.out_of_range !== want.out_of_range) begin
                    if (error_count < MAX_REPORTS)
                        $display("word %0d: expected %0d-%0d-%0d %0d:%0d:%0d oor %0b,",
                                 results_seen, want.year, want.month, want.day, want.hour,
                                 want.minute, want.second, want.out_of_range,
                                 " got %0d-%0d-%0d %0d:%0d:%0d oor %0b",
                                 got.year, got.month, got.day, got.hour, got.minute,
                                 got.second, got.out_of_range);
                    error_count++;
                end
            end
        end
    end

    // watchdog: counts cycles in which no word moves on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no word moved for %0d cycles, %0d dates still owed",
                 QUIET_LIMIT, pending_dates.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_field_extremes();
        test_block_boundaries();
        test_offset_extremes();
        test_random_dates();
        drain_pipeline();
        $display("run covered %0d words under %0d register writes",
                 words_sent, tz_writes);
        $display("%0d results checked, %0d of them outside years 0..9999, %0d failures",
                 results_seen, range_misses, error_count);
        if (error_count == 0 && pending_dates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ucal_pkg.sv
rtl/core/ucal_day_split.sv
rtl/core/ucal_year.sv
rtl/core/ucal_tod.sv
rtl/core/unix_seconds_to_calendar_core.sv
sim/tb_unix_seconds_to_calendar_core.sv
